/* design/blr_pkg.sv */
`timescale 1ns / 1ps

package blr_pkg;

  localparam int COORD_BITS  = 16;
  localparam int IN_BITS     = 15;
  localparam int PIX_BITS    = 12;
  localparam int COLOUR_BITS = 16;
  localparam int CFG_BITS    = 13;
  localparam int SCREEN_CAP  = 4096;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COORD_BITS:0]   wide_t;

  typedef struct packed {
    logic                   cmd;
    logic                   steep;
    coord_t                 major_pos;
    coord_t                 minor_pos;
    coord_t                 major_end;
    coord_t                 major_delta;
    coord_t                 minor_delta;
    coord_t                 error_term;
    logic                   minor_down;
    logic [COLOUR_BITS-1:0] colour;
  } entry_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] width_cap;
    logic [CFG_BITS-1:0] height_cap;
  } screen_t;

endpackage

/* design/blr_if.sv */
`timescale 1ns / 1ps

interface blr_cmd_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 cmd;
  logic signed [blr_pkg::IN_BITS-1:0]   start_x;
  logic signed [blr_pkg::IN_BITS-1:0]   start_y;
  logic signed [blr_pkg::IN_BITS-1:0]   finish_x;
  logic signed [blr_pkg::IN_BITS-1:0]   finish_y;
  logic [blr_pkg::COLOUR_BITS-1:0]      line_colour;

  modport source (output valid, cmd, start_x, start_y, finish_x, finish_y, line_colour,
                  input ready);
  modport sink (input valid, cmd, start_x, start_y, finish_x, finish_y, line_colour,
                output ready);
endinterface

interface blr_pixel_if;
  logic                            valid;
  logic                            ready;
  logic                            pixel_valid;
  logic [blr_pkg::PIX_BITS-1:0]    pixel_x;
  logic [blr_pkg::PIX_BITS-1:0]    pixel_y;
  logic [blr_pkg::COLOUR_BITS-1:0] pixel_colour;
  logic                            line_last;
  logic                            busy_res;

  modport source (output valid, pixel_valid, pixel_x, pixel_y, pixel_colour, line_last,
                  busy_res, input ready);
  modport sink (input valid, pixel_valid, pixel_x, pixel_y, pixel_colour, line_last,
                busy_res, output ready);
endinterface

/* design/bresenham_line_rasterizer.sv */
`timescale 1ns / 1ps

// Bresenham line rasterizer. A start beat on cmd_stream loads two endpoints and a colour and
// gives no pixel; each later tick beat gives one pixel beat on pixel_stream until the beat
// with line_last set, and ticks with no line in progress are dropped. The front end sets a
// line up in the cycle it is accepted, a two-entry queue parts it from the stepper, and the
// stepper makes one add-and-compare error step a cycle into an output register, so one pixel
// leaves per clock while pixel_stream.ready stays high. An accepted tick passes through the
// queue and then the output register. The user must write the screen size registers through
// cfg_we, cfg_index and cfg_data only while the block is idle; the block does not enforce it.
module bresenham_line_rasterizer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [blr_pkg::CFG_BITS-1:0] cfg_data,
  blr_cmd_if.sink                      cmd_stream,
  blr_pixel_if.source                  pixel_stream
);

  blr_pkg::screen_t screen;
  blr_pkg::entry_t  push_entry;
  blr_pkg::entry_t  pop_entry;
  logic             push;
  logic             push_ready;
  logic             pop;
  logic             pop_valid;
  logic [blr_pkg::CFG_BITS-1:0] cfg_capped;

  assign cfg_capped = (cfg_data > blr_pkg::CFG_BITS'(blr_pkg::SCREEN_CAP)) ?
                      blr_pkg::CFG_BITS'(blr_pkg::SCREEN_CAP) : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen.width_cap  <= blr_pkg::CFG_BITS'(320);
      screen.height_cap <= blr_pkg::CFG_BITS'(240);
    end else if (cfg_we) begin
      case (cfg_index)
        blr_pkg::REG_WIDTH:  screen.width_cap  <= cfg_capped;
        blr_pkg::REG_HEIGHT: screen.height_cap <= cfg_capped;
        default: ;
      endcase
    end
  end

  blr_front u_front (
    .cmd_stream (cmd_stream),
    .q_ready    (push_ready),
    .q_push     (push),
    .q_entry    (push_entry)
  );

  blr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry)
  );

  blr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .screen       (screen),
    .q_valid      (pop_valid),
    .q_entry      (pop_entry),
    .q_pop        (pop),
    .pixel_stream (pixel_stream)
  );

endmodule

/* design/blr_front.sv */
`timescale 1ns / 1ps

module blr_front (
  blr_cmd_if.sink         cmd_stream,
  input  logic            q_ready,
  output logic            q_push,
  output blr_pkg::entry_t q_entry
);

  blr_pkg::coord_t ax, ay, bx, by;
  blr_pkg::wide_t  dx, dy, adx, ady;
  blr_pkg::coord_t s0_major, s0_minor, s1_major, s1_minor;
  blr_pkg::coord_t lo_major, lo_minor, hi_major, hi_minor;
  blr_pkg::wide_t  dmaj, dmin, admin;
  logic            steep;
  logic            swap;

  always_comb begin
    ax = blr_pkg::coord_t'(cmd_stream.start_x);
    ay = blr_pkg::coord_t'(cmd_stream.start_y);
    bx = blr_pkg::coord_t'(cmd_stream.finish_x);
    by = blr_pkg::coord_t'(cmd_stream.finish_y);
    dx = blr_pkg::wide_t'(bx) - blr_pkg::wide_t'(ax);
    dy = blr_pkg::wide_t'(by) - blr_pkg::wide_t'(ay);
    adx = dx[blr_pkg::COORD_BITS] ? -dx : dx;
    ady = dy[blr_pkg::COORD_BITS] ? -dy : dy;
    steep = ady > adx;

    s0_major = steep ? ay : ax;
    s0_minor = steep ? ax : ay;
    s1_major = steep ? by : bx;
    s1_minor = steep ? bx : by;
    swap = s0_major > s1_major;
    lo_major = swap ? s1_major : s0_major;
    lo_minor = swap ? s1_minor : s0_minor;
    hi_major = swap ? s0_major : s1_major;
    hi_minor = swap ? s0_minor : s1_minor;

    dmaj  = blr_pkg::wide_t'(hi_major) - blr_pkg::wide_t'(lo_major);
    dmin  = blr_pkg::wide_t'(hi_minor) - blr_pkg::wide_t'(lo_minor);
    admin = dmin[blr_pkg::COORD_BITS] ? -dmin : dmin;

    q_entry.cmd         = cmd_stream.cmd;
    q_entry.steep       = steep;
    q_entry.major_pos   = lo_major;
    q_entry.minor_pos   = lo_minor;
    q_entry.major_end   = hi_major;
    q_entry.major_delta = blr_pkg::coord_t'(dmaj);
    q_entry.minor_delta = blr_pkg::coord_t'(admin);
    q_entry.error_term  = blr_pkg::coord_t'(dmaj >>> 1);
    q_entry.minor_down  = !(lo_minor < hi_minor);
    q_entry.colour      = cmd_stream.line_colour;
  end

  assign cmd_stream.ready = q_ready;
  assign q_push           = cmd_stream.valid && q_ready;

endmodule

/* design/blr_queue.sv */
`timescale 1ns / 1ps

module blr_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  blr_pkg::entry_t push_entry,
  output logic            push_ready,
  input  logic            pop,
  output logic            pop_valid,
  output blr_pkg::entry_t pop_entry
);

  blr_pkg::entry_t               slots [blr_pkg::QUEUE_DEPTH];
  logic [blr_pkg::QPTR_BITS-1:0] wr_ptr;
  logic [blr_pkg::QPTR_BITS-1:0] rd_ptr;
  logic [blr_pkg::QCNT_BITS-1:0] count;
  logic                          do_push;
  logic                          do_pop;

  assign push_ready = count != blr_pkg::QCNT_BITS'(blr_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_entry  = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == blr_pkg::QPTR_BITS'(blr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == blr_pkg::QPTR_BITS'(blr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* design/blr_back.sv */
`timescale 1ns / 1ps

module blr_back (
  input  logic             clk,
  input  logic             rst,
  input  blr_pkg::screen_t screen,
  input  logic             q_valid,
  input  blr_pkg::entry_t  q_entry,
  output logic             q_pop,
  blr_pixel_if.source      pixel_stream
);

  logic                            active;
  logic                            steep_flag;
  blr_pkg::coord_t                 major_pos;
  blr_pkg::coord_t                 minor_pos;
  blr_pkg::coord_t                 major_end;
  blr_pkg::coord_t                 major_delta;
  blr_pkg::coord_t                 minor_delta;
  blr_pkg::coord_t                 error_term;
  logic                            minor_down;
  logic [blr_pkg::COLOUR_BITS-1:0] held_colour;

  logic                            out_valid;
  logic                            out_pixel_valid;
  logic [blr_pkg::PIX_BITS-1:0]    out_x;
  logic [blr_pkg::PIX_BITS-1:0]    out_y;
  logic [blr_pkg::COLOUR_BITS-1:0] out_colour;
  logic                            out_last;
  logic                            out_busy;

  logic            out_free;
  logic            is_start;
  logic            do_step;
  blr_pkg::coord_t px, py;
  blr_pkg::coord_t err_sub;
  blr_pkg::coord_t minor_next;
  blr_pkg::coord_t error_next;
  logic            last;
  logic            vis;

  function automatic logic on_screen(blr_pkg::coord_t v, logic [blr_pkg::CFG_BITS-1:0] cap);
    on_screen = !v[blr_pkg::COORD_BITS-1] &&
                ({1'b0, v} < blr_pkg::wide_t'({1'b0, cap}));
  endfunction

  assign out_free = !out_valid || pixel_stream.ready;
  assign is_start = q_entry.cmd == blr_pkg::CMD_START;
  assign q_pop    = q_valid && (is_start || !active || out_free);
  assign do_step  = q_pop && !is_start && active;

  always_comb begin
    px   = steep_flag ? minor_pos : major_pos;
    py   = steep_flag ? major_pos : minor_pos;
    vis  = on_screen(px, screen.width_cap) && on_screen(py, screen.height_cap);
    last = major_pos == major_end;
    err_sub = error_term - minor_delta;
    if (err_sub[blr_pkg::COORD_BITS-1]) begin
      minor_next = minor_down ? minor_pos - blr_pkg::coord_t'(1) :
                                minor_pos + blr_pkg::coord_t'(1);
      error_next = err_sub + major_delta;
    end else begin
      minor_next = minor_pos;
      error_next = err_sub;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      steep_flag  <= 1'b0;
      major_pos   <= '0;
      minor_pos   <= '0;
      major_end   <= '0;
      major_delta <= '0;
      minor_delta <= '0;
      error_term  <= '0;
      minor_down  <= 1'b0;
      held_colour <= '0;
    end else if (q_pop && is_start) begin
      active      <= 1'b1;
      steep_flag  <= q_entry.steep;
      major_pos   <= q_entry.major_pos;
      minor_pos   <= q_entry.minor_pos;
      major_end   <= q_entry.major_end;
      major_delta <= q_entry.major_delta;
      minor_delta <= q_entry.minor_delta;
      error_term  <= q_entry.error_term;
      minor_down  <= q_entry.minor_down;
      held_colour <= q_entry.colour;
    end else if (do_step) begin
      minor_pos  <= minor_next;
      error_term <= error_next;
      major_pos  <= major_pos + blr_pkg::coord_t'(1);
      if (last) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_step) begin
      out_valid <= 1'b1;
    end else if (pixel_stream.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_step) begin
      out_pixel_valid <= vis;
      out_x           <= px[blr_pkg::PIX_BITS-1:0];
      out_y           <= py[blr_pkg::PIX_BITS-1:0];
      out_colour      <= held_colour;
      out_last        <= last;
      out_busy        <= !last;
    end
  end

  assign pixel_stream.valid        = out_valid;
  assign pixel_stream.pixel_valid  = out_pixel_valid;
  assign pixel_stream.pixel_x      = out_x;
  assign pixel_stream.pixel_y      = out_y;
  assign pixel_stream.pixel_colour = out_colour;
  assign pixel_stream.line_last    = out_last;
  assign pixel_stream.busy_res     = out_busy;

  a_step_gives_beat: assert property (@(posedge clk) disable iff (rst)
    do_step |=> out_valid)
    else $error("A pixel step did not leave a beat in the output register.");

  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    (do_step && last) |=> !active)
    else $error("The line stayed active after its final point.");

  a_start_loads: assert property (@(posedge clk) disable iff (rst)
    (q_pop && is_start) |=> (active && major_pos == $past(q_entry.major_pos)))
    else $error("A start command did not load the line.");

  a_last_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last != out_busy))
    else $error("A beat reported both the final point and remaining points.");

endmodule
